@@ design/ufmr_pkg.sv @@
// Package for the union-find engine: sizes, node type, operation codes,
// controller state encoding and the command and status words between modules.
// No dependencies.
`timescale 1ns / 1ps

package ufmr_pkg;

	localparam int NODE_COUNT = 16384;
	localparam int NODE_W     = $clog2(NODE_COUNT);
	localparam int FIELD_W    = 14;

	typedef logic [NODE_W-1:0]  node_t;
	typedef logic [FIELD_W-1:0] field_t;

	localparam logic KIND_UNION = 1'b0;
	localparam logic KIND_FIND  = 1'b1;

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_WALK  = 5'b00100,
		ST_COMP  = 5'b01000,
		ST_POST  = 5'b10000
	} state_t;

	typedef struct packed {
		logic clr_step;
		logic load;
		logic walk_step;
		logic comp_start;
		logic comp_step;
		logic second_start;
		logic finish;
	} cmd_t;

	typedef struct packed {
		logic clr_done;
		logic hit;
		logic node_is_root;
		logic is_find;
		logic out_free;
	} status_t;

	// Indices beyond the table saturate to the last node.
	function automatic node_t clamp_node(input field_t v);
		node_t r;
		if (32'(v) >= NODE_COUNT) begin
			r = node_t'(NODE_COUNT - 1);
		end else begin
			r = node_t'(v);
		end
		return r;
	endfunction

endpackage

@@ design/ufmr_ram.sv @@
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module ufmr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

@@ design/ufmr_ctrl.sv @@
// Controller for the union-find engine: sequences clearing, root walks,
// path compression, the second walk of a union and result hand-off. Uses ufmr_pkg.
`timescale 1ns / 1ps

module ufmr_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  ufmr_pkg::status_t st,
	output ufmr_pkg::cmd_t    cmd
);

	ufmr_pkg::state_t state_q, state_d;
	logic second_q, second_d;

	always_comb begin
		state_d  = state_q;
		second_d = second_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ufmr_pkg::ST_CLEAR: begin
				cmd.clr_step = 1'b1;
				if (st.clr_done) begin
					state_d = ufmr_pkg::ST_IDLE;
				end
			end
			ufmr_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					second_d = 1'b0;
					state_d  = ufmr_pkg::ST_WALK;
				end
			end
			ufmr_pkg::ST_WALK: begin
				if (st.hit) begin
					if (st.node_is_root) begin
						state_d = ufmr_pkg::ST_POST;
					end else begin
						cmd.comp_start = 1'b1;
						state_d        = ufmr_pkg::ST_COMP;
					end
				end else begin
					cmd.walk_step = 1'b1;
				end
			end
			ufmr_pkg::ST_COMP: begin
				cmd.comp_step = 1'b1;
				if (st.hit) begin
					state_d = ufmr_pkg::ST_POST;
				end
			end
			ufmr_pkg::ST_POST: begin
				if (!st.is_find && !second_q) begin
					cmd.second_start = 1'b1;
					second_d         = 1'b1;
					state_d          = ufmr_pkg::ST_WALK;
				end else if (st.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ufmr_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ufmr_pkg::ST_CLEAR;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ufmr_pkg::ST_CLEAR;
			second_q <= 1'b0;
		end else begin
			state_q  <= state_d;
			second_q <= second_d;
		end
	end

endmodule

@@ design/ufmr_dp.sv @@
// Datapath for the union-find engine: parent table, walk and compression
// registers, link write and the output word register. Uses ufmr_pkg, ufmr_ram.
`timescale 1ns / 1ps

module ufmr_dp (
	input  logic                  clk,
	input  logic                  arst_n,
	input  ufmr_pkg::cmd_t         cmd,
	output ufmr_pkg::status_t      st,
	input  logic                  kind,
	input  ufmr_pkg::field_t       first_node,
	input  ufmr_pkg::field_t       second_node,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ufmr_pkg::field_t       root,
	output logic                  merged
);

	ufmr_pkg::node_t clr_q, node_q, r_q, cur_q, ra_q, b_q, root_q;
	logic            kind_q, merged_q, out_valid_q;

	ufmr_pkg::node_t raddr, rdata, waddr, wdata, lo, hi;
	logic            we, distinct;

	ufmr_ram #(
		.WIDTH(ufmr_pkg::NODE_W),
		.DEPTH(ufmr_pkg::NODE_COUNT)
	) u_parent (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	// The first root is held in ra_q, the second is the walk register itself.
	assign distinct = (ra_q != r_q);
	assign lo       = (ra_q < r_q) ? ra_q : r_q;
	assign hi       = (ra_q < r_q) ? r_q : ra_q;

	always_comb begin
		if (cmd.load) begin
			raddr = ufmr_pkg::clamp_node(first_node);
		end else if (cmd.walk_step || cmd.comp_step) begin
			raddr = rdata;
		end else if (cmd.comp_start) begin
			raddr = node_q;
		end else if (cmd.second_start) begin
			raddr = b_q;
		end else begin
			raddr = r_q;
		end
	end

	always_comb begin
		we    = 1'b0;
		waddr = clr_q;
		wdata = clr_q;
		if (cmd.clr_step) begin
			we = 1'b1;
		end else if (cmd.comp_step) begin
			we    = 1'b1;
			waddr = cur_q;
			wdata = r_q;
		end else if (cmd.finish && kind_q == ufmr_pkg::KIND_UNION && distinct) begin
			we    = 1'b1;
			waddr = hi;
			wdata = lo;
		end
	end

	always_comb begin
		st.clr_done     = (clr_q == ufmr_pkg::node_t'(ufmr_pkg::NODE_COUNT - 1));
		st.hit          = (rdata == r_q);
		st.node_is_root = (node_q == r_q);
		st.is_find      = (kind_q == ufmr_pkg::KIND_FIND);
		st.out_free     = !out_valid_q || out_ready;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_step) begin
				clr_q <= clr_q + 1'b1;
			end
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			node_q <= ufmr_pkg::clamp_node(first_node);
			r_q    <= ufmr_pkg::clamp_node(first_node);
			b_q    <= ufmr_pkg::clamp_node(second_node);
		end
		if (cmd.walk_step) begin
			r_q <= rdata;
		end
		if (cmd.comp_start) begin
			cur_q <= node_q;
		end
		if (cmd.comp_step) begin
			cur_q <= rdata;
		end
		if (cmd.second_start) begin
			ra_q   <= r_q;
			node_q <= b_q;
			r_q    <= b_q;
		end
		if (cmd.finish) begin
			if (kind_q == ufmr_pkg::KIND_FIND) begin
				root_q   <= r_q;
				merged_q <= 1'b0;
			end else begin
				root_q   <= lo;
				merged_q <= distinct;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign root      = ufmr_pkg::field_t'(root_q);
	assign merged    = merged_q;

	// Every link points to a lower index, so a walk always descends.
	a_walk_descends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk_step |-> (rdata < r_q))
		else $error("root walk followed a link that does not descend");

	a_comp_descends: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.comp_step |-> (r_q < cur_q))
		else $error("compression wrote a link that does not descend");

	a_finish_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || out_ready))
		else $error("result overwrote a word not yet taken");

endmodule

@@ design/union_find_min_root_unit.sv @@
// Union-find engine, min-index root: one find or union per word, one result word each.
// A find walks from its node to the root and compresses the path if the node is not the root;
// a union does so for both nodes, then links the higher root to the lower. The result word is registered.
// One word at a time: in_ready is high only while idle, and a result waits until the output word is free.
// After reset the table is cleared to identity, every node its own parent, with in_ready held low.
// Depends on ufmr_pkg, ufmr_ctrl, ufmr_dp, ufmr_ram.
`timescale 1ns / 1ps

module union_find_min_root_unit (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             kind,
	input  ufmr_pkg::field_t first_node,
	input  ufmr_pkg::field_t second_node,
	output logic             out_valid,
	input  logic             out_ready,
	output ufmr_pkg::field_t root,
	output logic             merged
);

	ufmr_pkg::cmd_t    cmd;
	ufmr_pkg::status_t st;

	ufmr_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	ufmr_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.st         (st),
		.kind       (kind),
		.first_node (first_node),
		.second_node(second_node),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.root       (root),
		.merged     (merged)
	);

endmodule
